### src/wav_header_parser_top_defines.svh
// Assertion macros used by the WAV header parser top level.
`ifndef WAV_HEADER_PARSER_TOP_DEFINES_SVH
`define WAV_HEADER_PARSER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define WHP_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define WHP_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define WHP_ASSERT(label, clk, rstn, prop, msg)
`define WHP_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

### src/whp_pkg.sv
// Shared types and constants of the WAV header parser.
`timescale 1ns / 1ps
`default_nettype none

package whp_pkg;

  localparam int unsigned QueueDepthDef = 2;

  localparam logic [31:0] TagRiff = 32'h4646_4952;
  localparam logic [31:0] TagWave = 32'h4556_4157;
  localparam logic [31:0] TagFmt  = 32'h2074_6d66;
  localparam logic [31:0] TagData = 32'h6174_6164;

  localparam logic [31:0] FmtMinSize = 32'd16;
  localparam logic [15:0] PcmFormat  = 16'd1;
  localparam logic [15:0] MonoCount  = 16'd1;
  localparam logic [15:0] SampleBits = 16'd16;
  localparam logic [15:0] BlockAlign = 16'd2;

  typedef enum logic [1:0] {
    VerdictParsing  = 2'd0,
    VerdictAccepted = 2'd1,
    VerdictRejected = 2'd2
  } whp_verdict_e;

  localparam int unsigned OutDataW = 72;

  typedef struct packed {
    logic       sof;
    logic [7:0] data;
  } whp_item_t;

endpackage

`default_nettype wire

### src/whp_queue.sv
// Input queue that takes byte transfers and hands them to the parser.
`timescale 1ns / 1ps
`default_nettype none

module whp_queue #(
  parameter int unsigned Depth = 2
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                push_valid_i,
  output logic               push_ready_o,
  input  whp_pkg::whp_item_t push_item_i,
  output logic               pop_valid_o,
  input  wire                pop_ready_i,
  output whp_pkg::whp_item_t pop_item_o
);
  import whp_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  whp_item_t       mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push, pop;

  assign push_ready_o = (count_q != FullCnt);
  assign pop_valid_o  = (count_q != '0);
  assign pop_item_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CntW'(1);
    end else if (pop && !push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

### src/whp_parser.sv
// Header parsing state machine with the registered result output.
`timescale 1ns / 1ps
`default_nettype none

module whp_parser (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               item_valid_i,
  output logic                              item_ready_o,
  input  whp_pkg::whp_item_t                item_i,
  output logic                              m_axis_tvalid_o,
  input  wire                               m_axis_tready_i,
  output logic [whp_pkg::OutDataW-1:0]      m_axis_tdata_o
);
  import whp_pkg::*;

  localparam logic [2:0] PhRiff     = 3'd0;
  localparam logic [2:0] PhRiffSize = 3'd1;
  localparam logic [2:0] PhWave     = 3'd2;
  localparam logic [2:0] PhId       = 3'd3;
  localparam logic [2:0] PhSize     = 3'd4;
  localparam logic [2:0] PhFmt      = 3'd5;
  localparam logic [2:0] PhSkip     = 3'd6;
  localparam logic [2:0] PhDone     = 3'd7;

  logic [2:0]   phase_q, phase_d, phase_b;
  logic [3:0]   pos_q, pos_d, pos_b;
  logic [31:0]  word_q, word_d, word_b;
  logic [31:0]  tag_q, tag_d, tag_b;
  logic [31:0]  skip_q, skip_d, skip_b;
  logic         fmt_seen_q, fmt_seen_d, fmt_seen_b;
  logic [15:0]  format_q, format_d, format_b;
  logic [15:0]  chans_q, chans_d, chans_b;
  logic [31:0]  rate_q, rate_d, rate_b;
  logic [31:0]  brate_q, brate_d, brate_b;
  logic [15:0]  align_q, align_d, align_b;
  whp_verdict_e verdict_q, verdict_d, verdict_b;
  logic [31:0]  size_q, size_d, size_b;
  logic         out_valid_q, out_valid_d;

  logic         take;
  logic [31:0]  word_new;
  logic [3:0]   pos_inc;
  logic [31:0]  skip_dec;
  logic [31:0]  brate_expect;
  logic         fmt_ok;
  logic [31:0]  size_out;

  assign item_ready_o = !out_valid_q || m_axis_tready_i;
  assign take         = item_valid_i && item_ready_o;

  always_comb begin
    if (item_i.sof) begin
      phase_b    = PhRiff;
      pos_b      = '0;
      word_b     = '0;
      tag_b      = '0;
      skip_b     = '0;
      fmt_seen_b = 1'b0;
      format_b   = '0;
      chans_b    = '0;
      rate_b     = '0;
      brate_b    = '0;
      align_b    = '0;
      verdict_b  = VerdictParsing;
      size_b     = '0;
    end else begin
      phase_b    = phase_q;
      pos_b      = pos_q;
      word_b     = word_q;
      tag_b      = tag_q;
      skip_b     = skip_q;
      fmt_seen_b = fmt_seen_q;
      format_b   = format_q;
      chans_b    = chans_q;
      rate_b     = rate_q;
      brate_b    = brate_q;
      align_b    = align_q;
      verdict_b  = verdict_q;
      size_b     = size_q;
    end
  end

  assign word_new     = {item_i.data, word_b[31:8]};
  assign pos_inc      = pos_b + 4'd1;
  assign skip_dec     = (skip_b != '0) ? skip_b - 32'd1 : skip_b;
  assign brate_expect = {3'b000, rate_b[27:0], 1'b0};
  assign fmt_ok       = (format_b == PcmFormat) && (chans_b == MonoCount) &&
                        (word_new[31:16] == SampleBits) &&
                        (brate_b == brate_expect) && (align_b == BlockAlign);

  always_comb begin
    phase_d    = phase_b;
    pos_d      = pos_b;
    word_d     = word_b;
    tag_d      = tag_b;
    skip_d     = skip_b;
    fmt_seen_d = fmt_seen_b;
    format_d   = format_b;
    chans_d    = chans_b;
    rate_d     = rate_b;
    brate_d    = brate_b;
    align_d    = align_b;
    verdict_d  = verdict_b;
    size_d     = size_b;
    if (verdict_b == VerdictParsing) begin
      case (phase_b)
        PhRiff, PhRiffSize, PhWave, PhId, PhSize: begin
          word_d = word_new;
          if (pos_inc >= 4'd4) begin
            pos_d = '0;
            case (phase_b)
              PhRiff: begin
                if (word_new == TagRiff) begin
                  phase_d = PhRiffSize;
                end else begin
                  verdict_d = VerdictRejected;
                  phase_d   = PhDone;
                end
              end
              PhRiffSize: begin
                phase_d = PhWave;
              end
              PhWave: begin
                if (word_new == TagWave) begin
                  phase_d = PhId;
                end else begin
                  verdict_d = VerdictRejected;
                  phase_d   = PhDone;
                end
              end
              PhId: begin
                tag_d   = word_new;
                phase_d = PhSize;
              end
              default: begin
                if (tag_b == TagFmt) begin
                  fmt_seen_d = 1'b1;
                  if (word_new < FmtMinSize) begin
                    verdict_d = VerdictRejected;
                    phase_d   = PhDone;
                  end else begin
                    skip_d  = word_new - FmtMinSize;
                    phase_d = PhFmt;
                  end
                end else if (tag_b == TagData) begin
                  phase_d = PhDone;
                  if (!fmt_seen_b || (word_new == '0)) begin
                    verdict_d = VerdictRejected;
                  end else begin
                    size_d    = word_new;
                    verdict_d = VerdictAccepted;
                  end
                end else begin
                  skip_d  = word_new;
                  phase_d = (word_new == '0) ? PhId : PhSkip;
                end
              end
            endcase
          end else begin
            pos_d = pos_inc;
          end
        end
        PhFmt: begin
          word_d = word_new;
          pos_d  = pos_inc;
          case (pos_b)
            4'd1:  format_d = word_new[31:16];
            4'd3:  chans_d  = word_new[31:16];
            4'd7:  rate_d   = word_new;
            4'd11: brate_d  = word_new;
            4'd13: align_d  = word_new[31:16];
            4'd15: begin
              pos_d = '0;
              if (fmt_ok) begin
                phase_d = (skip_b == '0) ? PhId : PhSkip;
              end else begin
                verdict_d = VerdictRejected;
                phase_d   = PhDone;
              end
            end
            default: ;
          endcase
        end
        PhSkip: begin
          skip_d = skip_dec;
          if (skip_dec == '0) begin
            phase_d = PhId;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    if (take) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhRiff;
      pos_q       <= '0;
      word_q      <= '0;
      tag_q       <= '0;
      skip_q      <= '0;
      fmt_seen_q  <= 1'b0;
      format_q    <= '0;
      chans_q     <= '0;
      rate_q      <= '0;
      brate_q     <= '0;
      align_q     <= '0;
      verdict_q   <= VerdictParsing;
      size_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (take) begin
        phase_q    <= phase_d;
        pos_q      <= pos_d;
        word_q     <= word_d;
        tag_q      <= tag_d;
        skip_q     <= skip_d;
        fmt_seen_q <= fmt_seen_d;
        format_q   <= format_d;
        chans_q    <= chans_d;
        rate_q     <= rate_d;
        brate_q    <= brate_d;
        align_q    <= align_d;
        verdict_q  <= verdict_d;
        size_q     <= size_d;
      end
    end
  end

  assign size_out        = (verdict_q == VerdictAccepted) ? size_q : '0;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'b000000, rate_q, size_out, verdict_q};

endmodule

`default_nettype wire

### src/wav_header_parser_top.sv
// Top level of the WAV header parser: input queue and parser back end.
// The slave stream takes one file byte per transfer in tdata[7:0], with
// tuser set on the first byte of a new file to restart parsing. Every
// accepted byte produces exactly one transfer on the master stream that
// carries the current verdict (parsing, accepted or rejected), the data
// chunk size when accepted and the sample rate of the last fmt chunk.
// A byte is written into the input queue, then taken by the parser, and its
// result is held in the output register that drives the master side.
// The block sustains one byte per cycle while the receiver takes every
// result; the parser state machine updates all of its counters and fields
// for a byte as it takes that byte.
// The verdict holds once reached until the next start of file.
// Reset clears the queue, the parser state and the output register, so the
// first file may begin with or without the start flag.
// When the receiver stalls, the result stays in the output register and the
// queue keeps taking bytes until it is full, after which tready drops.
`timescale 1ns / 1ps
`default_nettype none
`include "wav_header_parser_top_defines.svh"

module wav_header_parser_top #(
  parameter int unsigned QueueDepth = whp_pkg::QueueDepthDef
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // data_byte [7:0]
  input  wire  [7:0]                   s_axis_tdata_i,
  // start_of_file [0]
  input  wire                          s_axis_tuser_i,
  output logic                         m_axis_tvalid_o,
  input  wire                          m_axis_tready_i,
  // verdict [1:0], data_size [33:2], sample_rate [65:34], zero fill [71:66]
  output logic [whp_pkg::OutDataW-1:0] m_axis_tdata_o
);
  import whp_pkg::*;

  whp_item_t in_item;
  whp_item_t q_item;
  logic      q_valid;
  logic      q_ready;

  assign in_item.sof  = s_axis_tuser_i;
  assign in_item.data = s_axis_tdata_i;

  whp_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(s_axis_tvalid_i),
    .push_ready_o(s_axis_tready_o),
    .push_item_i (in_item),
    .pop_valid_o (q_valid),
    .pop_ready_i (q_ready),
    .pop_item_o  (q_item)
  );

  whp_parser u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_valid_i   (q_valid),
    .item_ready_o   (q_ready),
    .item_i         (q_item),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  `WHP_ASSERT(a_verdict_code, clk_i, rst_ni, m_axis_tvalid_o |-> (m_axis_tdata_o[1:0] != 2'b11), "Verdict code out of range.")
  `WHP_ASSERT(a_size_masked, clk_i, rst_ni, (m_axis_tvalid_o && (m_axis_tdata_o[1:0] != 2'b01)) |-> (m_axis_tdata_o[33:2] == 32'd0), "Data size shown without acceptance.")
  `WHP_ASSERT(a_full_has_data, clk_i, rst_ni, !s_axis_tready_o |-> q_valid, "Queue reports full while empty.")

endmodule

`default_nettype wire

### tb/tb_wav_header_parser_top.sv
// Self-checking stream testbench for the WAV header parser with a built-in header predictor.
`timescale 1ns / 1ps

module tb_wav_header_parser_top;
  import whp_pkg::*;

  localparam int unsigned ItemTarget = 1100;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned DirRows = 22;
  localparam int unsigned TailCycles = 20;

  typedef enum logic [3:0] {
    PhRiff, PhRiffSize, PhWave, PhId, PhSize, PhFmt, PhSkip, PhDone
  } parse_phase_e;

  typedef struct packed {
    whp_verdict_e verdict;
    logic [31:0]  size;
    logic [31:0]  rate;
  } wav_result_t;

  typedef struct packed {
    logic [7:0]   b;
    logic         sof;
    logic         typed;
    whp_verdict_e v;
  } dir_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid_i;
  logic                s_axis_tready_o;
  logic [7:0]          s_axis_tdata_i;
  logic                s_axis_tuser_i;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i;
  logic [OutDataW-1:0] m_axis_tdata_o;

  logic        row_typed;
  wav_result_t row_result;

  parse_phase_e phase;
  logic [4:0]   pos;
  logic [31:0]  shift_word;
  logic [31:0]  cur_tag;
  logic [31:0]  skip_cnt;
  logic         fmt_found;
  logic [15:0]  fmt_code;
  logic [15:0]  chans;
  logic [31:0]  srate;
  logic [31:0]  brate;
  logic [15:0]  balign;
  whp_verdict_e verdict;
  logic [31:0]  dsize;

  wav_result_t pending_verdicts[$];
  logic [7:0]  file_bytes[$];
  int unsigned mismatch_count;
  int unsigned cycle_count;
  int unsigned sent_count;
  int unsigned src_mode;

  wav_header_parser_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic void clear_parser();
    phase      = PhRiff;
    pos        = '0;
    shift_word = '0;
    cur_tag    = '0;
    skip_cnt   = '0;
    fmt_found  = 1'b0;
    fmt_code   = '0;
    chans      = '0;
    srate      = '0;
    brate      = '0;
    balign     = '0;
    verdict    = VerdictParsing;
    dsize      = '0;
  endfunction

  function automatic wav_result_t parse_byte(input logic [7:0] b, input logic sof);
    wav_result_t r;
    logic [3:0]  p;
    logic [31:0] w;
    logic [31:0] rate_x16;
    if (sof) clear_parser();
    if (verdict == VerdictParsing) begin
      if (phase == PhFmt) begin
        shift_word = {b, shift_word[31:8]};
        p = pos[3:0];
        case (p)
          4'd1: fmt_code = shift_word[31:16];
          4'd3: chans = shift_word[31:16];
          4'd7: srate = shift_word;
          4'd11: brate = shift_word;
          4'd13: balign = shift_word[31:16];
          default: ;
        endcase
        if (p == 4'd15) begin
          pos = '0;
          rate_x16 = srate << 4;
          if (fmt_code == PcmFormat && chans == MonoCount && shift_word[31:16] == SampleBits &&
              brate == (rate_x16 >> 3) && balign == BlockAlign) begin
            if (skip_cnt == 0) phase = PhId;
            else phase = PhSkip;
          end else begin
            verdict = VerdictRejected;
            phase = PhDone;
          end
        end else begin
          pos = {1'b0, p} + 5'd1;
        end
      end else if (phase == PhSkip) begin
        if (skip_cnt != 0) skip_cnt = skip_cnt - 1;
        if (skip_cnt == 0) phase = PhId;
      end else if (phase != PhDone) begin
        shift_word = {b, shift_word[31:8]};
        pos = pos + 5'd1;
        if (pos >= 5'd4) begin
          pos = '0;
          w = shift_word;
          case (phase)
            PhRiff: begin
              if (w == TagRiff) begin
                phase = PhRiffSize;
              end else begin
                verdict = VerdictRejected;
                phase = PhDone;
              end
            end
            PhRiffSize: phase = PhWave;
            PhWave: begin
              if (w == TagWave) begin
                phase = PhId;
              end else begin
                verdict = VerdictRejected;
                phase = PhDone;
              end
            end
            PhId: begin
              cur_tag = w;
              phase = PhSize;
            end
            default: begin
              if (cur_tag == TagFmt) begin
                fmt_found = 1'b1;
                if (w < FmtMinSize) begin
                  verdict = VerdictRejected;
                  phase = PhDone;
                end else begin
                  skip_cnt = w - FmtMinSize;
                  phase = PhFmt;
                end
              end else if (cur_tag == TagData) begin
                if (!fmt_found || w == 0) begin
                  verdict = VerdictRejected;
                end else begin
                  dsize = w;
                  verdict = VerdictAccepted;
                end
                phase = PhDone;
              end else begin
                skip_cnt = w;
                if (w == 0) phase = PhId;
                else phase = PhSkip;
              end
            end
          endcase
        end
      end
    end
    r.verdict = verdict;
    r.size = (verdict == VerdictAccepted) ? dsize : 32'd0;
    r.rate = srate;
    return r;
  endfunction

  function automatic dir_row_t dir_row(input int unsigned i);
    dir_row_t r;
    case (i)
      0:  r = '{8'h52, 1'b0, 1'b1, VerdictParsing};
      1:  r = '{8'h49, 1'b0, 1'b0, VerdictParsing};
      2:  r = '{8'h46, 1'b0, 1'b0, VerdictParsing};
      3:  r = '{8'h00, 1'b0, 1'b1, VerdictRejected};
      4:  r = '{8'hFF, 1'b0, 1'b1, VerdictRejected};
      5:  r = '{8'h52, 1'b1, 1'b0, VerdictParsing};
      6:  r = '{8'h49, 1'b0, 1'b0, VerdictParsing};
      7:  r = '{8'h46, 1'b0, 1'b0, VerdictParsing};
      8:  r = '{8'h46, 1'b0, 1'b0, VerdictParsing};
      9:  r = '{8'h00, 1'b0, 1'b0, VerdictParsing};
      10: r = '{8'hFF, 1'b0, 1'b0, VerdictParsing};
      11: r = '{8'h00, 1'b0, 1'b0, VerdictParsing};
      12: r = '{8'hFF, 1'b0, 1'b0, VerdictParsing};
      13: r = '{8'h57, 1'b0, 1'b0, VerdictParsing};
      14: r = '{8'h41, 1'b0, 1'b0, VerdictParsing};
      15: r = '{8'h56, 1'b0, 1'b0, VerdictParsing};
      16: r = '{8'h44, 1'b0, 1'b1, VerdictRejected};
      17: r = '{8'h52, 1'b1, 1'b1, VerdictParsing};
      18: r = '{8'h49, 1'b0, 1'b0, VerdictParsing};
      19: r = '{8'h46, 1'b0, 1'b0, VerdictParsing};
      20: r = '{8'h46, 1'b0, 1'b0, VerdictParsing};
      default: r = '{8'h00, 1'b1, 1'b1, VerdictParsing};
    endcase
    return r;
  endfunction

  function automatic int unsigned idle_draw(input int unsigned mode);
    return (mode == 0) ? 0 : $urandom_range(0, 19);
  endfunction

  function automatic logic [31:0] maybe_flip(input logic [31:0] w, input int unsigned odds,
                                             input int unsigned nbits);
    if ($urandom_range(0, odds - 1) == 0) return w ^ (32'd1 << $urandom_range(0, nbits - 1));
    return w;
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%s", msg);
  endtask

  task automatic send_item(input logic [7:0] b, input logic sof, input logic typed,
                           input wav_result_t res);
    int unsigned idle;
    idle = idle_draw(src_mode);
    if (idle > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (idle) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    s_axis_tuser_i  <= sof;
    row_typed       <= typed;
    row_result      <= res;
    do @(posedge clk_i); while (!(s_axis_tvalid_i && s_axis_tready_o));
    @(negedge clk_i);
  endtask

  task automatic put_bytes(input logic [31:0] w, input int unsigned n);
    for (int unsigned k = 0; k < n; k++) file_bytes.push_back(w[8*k +: 8]);
  endtask

  task automatic put_fmt_chunk();
    int unsigned len;
    logic [31:0] rate;
    logic [31:0] rate_x16;
    int unsigned sel;
    put_bytes(TagFmt, 4);
    if ($urandom_range(0, 9) == 0) begin
      put_bytes($urandom_range(0, 15), 4);
      return;
    end
    len = 16 + $urandom_range(0, 5);
    put_bytes(len, 4);
    sel = $urandom_range(0, 9);
    rate = (sel == 0) ? 32'd0 : (sel == 1) ? 32'hFFFF_FFFF : $urandom;
    rate_x16 = rate << 4;
    put_bytes(maybe_flip(PcmFormat, 12, 16), 2);
    put_bytes(maybe_flip(MonoCount, 12, 16), 2);
    put_bytes(rate, 4);
    put_bytes(maybe_flip(rate_x16 >> 3, 12, 32), 4);
    put_bytes(maybe_flip(BlockAlign, 12, 16), 2);
    put_bytes(maybe_flip(SampleBits, 12, 16), 2);
    repeat (len - 16) file_bytes.push_back($urandom_range(0, 255));
  endtask

  task automatic build_file();
    int unsigned npre;
    int unsigned sel;
    int unsigned keep;
    logic [31:0] size;
    logic        have_fmt;
    file_bytes.delete();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 12)) file_bytes.push_back($urandom_range(0, 255));
      return;
    end
    put_bytes(maybe_flip(TagRiff, 20, 32), 4);
    put_bytes($urandom, 4);
    put_bytes(maybe_flip(TagWave, 20, 32), 4);
    have_fmt = 1'b0;
    npre = $urandom_range(0, 3);
    for (int unsigned c = 0; c < npre; c++) begin
      if ($urandom_range(0, 1) == 1) begin
        put_fmt_chunk();
        have_fmt = 1'b1;
      end else begin
        put_bytes($urandom, 4);
        size = ($urandom_range(0, 14) == 0) ? $urandom : $urandom_range(0, 9);
        put_bytes(size, 4);
        repeat ((size > 9) ? $urandom_range(0, 9) : size) file_bytes.push_back($urandom_range(0, 255));
      end
    end
    if (!have_fmt && $urandom_range(0, 3) != 0) put_fmt_chunk();
    put_bytes(TagData, 4);
    sel = $urandom_range(0, 9);
    size = (sel == 0) ? 32'd0 : (sel == 1) ? 32'hFFFF_FFFF : (sel == 2) ? $urandom :
           $urandom_range(1, 65535);
    put_bytes(size, 4);
    repeat ($urandom_range(0, 3)) file_bytes.push_back($urandom_range(0, 255));
    if ($urandom_range(0, 7) == 0) begin
      keep = $urandom_range(1, file_bytes.size());
      while (file_bytes.size() > keep) void'(file_bytes.pop_back());
    end
  endtask

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk_i) begin : check_p
    wav_result_t want;
    wav_result_t predicted;
    logic [1:0]  got_verdict;
    logic [31:0] got_size;
    logic [31:0] got_rate;
    logic [5:0]  got_pad;
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        predicted = parse_byte(s_axis_tdata_i, s_axis_tuser_i);
        pending_verdicts.push_back(row_typed ? row_result : predicted);
      end
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got_verdict = m_axis_tdata_o[1:0];
        got_size    = m_axis_tdata_o[33:2];
        got_rate    = m_axis_tdata_o[65:34];
        got_pad     = m_axis_tdata_o[71:66];
        if (pending_verdicts.size() == 0) begin
          flag_mismatch($sformatf("unexpected result transfer: verdict %0d size %h rate %h",
                                  got_verdict, got_size, got_rate));
        end else begin
          want = pending_verdicts.pop_front();
          if (got_verdict != want.verdict || got_size != want.size || got_rate != want.rate ||
              got_pad != 6'd0) begin
            flag_mismatch($sformatf(
              "mismatch: verdict %0d/%0d size %h/%h rate %h/%h pad %h (expected/actual)",
              want.verdict, got_verdict, want.size, got_size, want.rate, got_rate, got_pad));
          end
        end
      end
    end
  end

  initial begin : sink_p
    int unsigned idle;
    int unsigned got_count;
    int unsigned sink_mode;
    m_axis_tready_i = 1'b0;
    got_count = 0;
    sink_mode = 1;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (got_count % 64 == 0) sink_mode = $urandom_range(0, 2);
      idle = (got_count % 500 == 200) ? 200 : idle_draw(sink_mode);
      if (idle > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (idle) @(negedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid_o && m_axis_tready_i));
      got_count++;
      @(negedge clk_i);
    end
  end

  initial begin : source_p
    dir_row_t    row;
    wav_result_t typed_res;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = 8'h00;
    s_axis_tuser_i  = 1'b0;
    row_typed       = 1'b0;
    row_result      = '0;
    mismatch_count  = 0;
    cycle_count     = 0;
    sent_count      = 0;
    src_mode        = 1;
    clear_parser();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int unsigned i = 0; i < DirRows; i++) begin
      row = dir_row(i);
      typed_res = '{row.v, 32'd0, 32'd0};
      send_item(row.b, row.sof, row.typed, typed_res);
      sent_count++;
    end

    while (sent_count < ItemTarget) begin
      src_mode = ($urandom_range(0, 3) == 0) ? 0 : 1;
      build_file();
      for (int unsigned k = 0; k < file_bytes.size(); k++) begin
        send_item(file_bytes[k], (k == 0) && ($urandom_range(0, 19) != 0), 1'b0, '0);
        sent_count++;
      end
    end
    s_axis_tvalid_i <= 1'b0;

    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (pending_verdicts.size() != 0) begin
      flag_mismatch($sformatf("%0d results never arrived", pending_verdicts.size()));
    end
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
